// ----- hw/rtl/tse_pkg.sv -----
`default_nettype none

package tse_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       doc_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // One command per input transaction: the segments to emit, in this order.
  typedef struct packed {
    logic       open_first;  // opening string before the first byte
    logic [1:0] pre_cnt;     // held tag prefix bytes flushed as text
    logic       close_mid;   // tag opened: closing string
    logic       open_mid;    // tag closed: opening string
    logic       q_mid;       // held '?' released in code
    logic       esc_mid;     // backslash in front of byte_val
    logic       byte_mid;    // byte_val itself
    logic [7:0] byte_val;
    logic       end_q;       // held '?' at end of document
    logic       end_open;    // opening string at end inside code
    logic [1:0] post_cnt;    // held tag prefix bytes at end of document
    logic       end_close;   // closing string at end
  } cmd_t;

  typedef enum logic [3:0] {
    SEG_OPEN_FIRST,
    SEG_PRE,
    SEG_CLOSE_MID,
    SEG_OPEN_MID,
    SEG_Q_MID,
    SEG_ESC,
    SEG_BYTE,
    SEG_END_Q,
    SEG_END_OPEN,
    SEG_POST,
    SEG_END_CLOSE
  } seg_t;

  localparam int NUM_SEG    = 11;
  localparam int SEG_W      = 4;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int OPEN_LEN   = 20;
  localparam int CLOSE_LEN  = 3;
  localparam int TAG_LEN    = 4;
  localparam int IDX_W      = $clog2(OPEN_LEN);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic [7:0] OPEN_STR [OPEN_LEN] = '{
    "o", "u", "t", "p", "u", "t", "B", "u", "f", "f",
    "e", "r", ".", "w", "r", "i", "t", "e", "(", "\""
  };

  localparam logic [7:0] CLOSE_STR [CLOSE_LEN] = '{"\"", ")", ";"};

  localparam logic [7:0] TAG_OPEN [TAG_LEN] = '{"<", "?", "j", "s"};

  function automatic logic [NUM_SEG-1:0] cmd_mask(input cmd_t c);
    logic [NUM_SEG-1:0] m;
    m                 = '0;
    m[SEG_OPEN_FIRST] = c.open_first;
    m[SEG_PRE]        = (c.pre_cnt != 2'd0);
    m[SEG_CLOSE_MID]  = c.close_mid;
    m[SEG_OPEN_MID]   = c.open_mid;
    m[SEG_Q_MID]      = c.q_mid;
    m[SEG_ESC]        = c.esc_mid;
    m[SEG_BYTE]       = c.byte_mid;
    m[SEG_END_Q]      = c.end_q;
    m[SEG_END_OPEN]   = c.end_open;
    m[SEG_POST]       = (c.post_cnt != 2'd0);
    m[SEG_END_CLOSE]  = c.end_close;
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tse_front.sv -----
`default_nettype none

module tse_front
  import tse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          push,
  output cmd_t          push_cmd
);

  logic       in_code_r, in_code_nxt;
  logic [1:0] depth_r, depth_nxt;
  logic       started_r, started_nxt;

  logic       ic;
  logic [1:0] md;
  logic       ic_n;
  logic [1:0] md_n;
  logic [7:0] b;
  cmd_t       cmd;
  logic       accept;

  assign b        = in_item.data_byte;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ic   = started_r ? in_code_r : 1'b0;
    md   = started_r ? depth_r : 2'd0;
    ic_n = ic;
    md_n = md;
    cmd            = '0;
    cmd.open_first = !started_r;
    cmd.byte_val   = b;

    if (!ic) begin
      if (b == TAG_OPEN[md]) begin
        if (md == 2'(TAG_LEN - 1)) begin
          cmd.close_mid = 1'b1;
          ic_n          = 1'b1;
          md_n          = 2'd0;
        end else begin
          md_n = md + 2'd1;
        end
      end else begin
        // flush the failed prefix, then treat the byte afresh
        cmd.pre_cnt = md;
        md_n        = 2'd0;
        if (b == CH_LT) begin
          md_n = 2'd1;
        end else begin
          cmd.byte_mid = 1'b1;
          case (b)
            CH_BSL, CH_DQ: begin
              cmd.esc_mid = 1'b1;
            end
            CH_TAB: begin
              cmd.esc_mid  = 1'b1;
              cmd.byte_val = CH_T;
            end
            CH_LF: begin
              cmd.esc_mid  = 1'b1;
              cmd.byte_val = CH_N;
            end
            CH_CR: begin
              cmd.esc_mid  = 1'b1;
              cmd.byte_val = CH_R;
            end
            default: begin
              cmd.esc_mid = 1'b0;
            end
          endcase
        end
      end
    end else begin
      if (md == 2'd0) begin
        if (b == CH_QMARK) begin
          md_n = 2'd1;
        end else begin
          cmd.byte_mid = 1'b1;
        end
      end else if (b == CH_GT) begin
        cmd.open_mid = 1'b1;
        ic_n         = 1'b0;
        md_n         = 2'd0;
      end else if (b == CH_QMARK) begin
        cmd.q_mid = 1'b1;
      end else begin
        cmd.q_mid    = 1'b1;
        cmd.byte_mid = 1'b1;
        md_n         = 2'd0;
      end
    end

    if (in_item.doc_end) begin
      cmd.end_close = 1'b1;
      if (ic_n) begin
        cmd.end_q    = (md_n != 2'd0);
        cmd.end_open = 1'b1;
      end else begin
        cmd.post_cnt = md_n;
      end
    end
  end

  always_comb begin
    in_code_nxt = in_code_r;
    depth_nxt   = depth_r;
    started_nxt = started_r;
    if (accept) begin
      if (in_item.doc_end) begin
        in_code_nxt = 1'b0;
        depth_nxt   = 2'd0;
        started_nxt = 1'b0;
      end else begin
        in_code_nxt = ic_n;
        depth_nxt   = md_n;
        started_nxt = 1'b1;
      end
    end
  end

  // drop transactions that produce nothing
  assign push     = accept && (cmd_mask(cmd) != '0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_code_r <= 1'b0;
      depth_r   <= 2'd0;
      started_r <= 1'b0;
    end else begin
      in_code_r <= in_code_nxt;
      depth_r   <= depth_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tse_cmd_fifo.sv -----
`default_nettype none

module tse_cmd_fifo
  import tse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_PTR_W:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tse_back.sv -----
`default_nettype none

module tse_back
  import tse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  logic               w_valid_r, w_valid_nxt;
  logic [NUM_SEG-1:0] mask_r, mask_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  cmd_t               w_cmd_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  seg_t               seg;
  logic [IDX_W-1:0]   last_idx;
  logic [7:0]         cur_byte;
  logic               seg_done;
  logic [NUM_SEG-1:0] rest;
  logic               run_last;
  logic               adv;
  logic               emit;
  logic               load;

  // lowest pending segment goes first
  always_comb begin
    seg = SEG_OPEN_FIRST;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        seg = seg_t'(SEG_W'(i));
      end
    end
  end

  always_comb begin
    last_idx = '0;
    cur_byte = w_cmd_r.byte_val;
    case (seg)
      SEG_OPEN_FIRST, SEG_OPEN_MID, SEG_END_OPEN: begin
        last_idx = IDX_W'(OPEN_LEN - 1);
        cur_byte = OPEN_STR[idx_r];
      end
      SEG_CLOSE_MID, SEG_END_CLOSE: begin
        last_idx = IDX_W'(CLOSE_LEN - 1);
        cur_byte = CLOSE_STR[idx_r[1:0]];
      end
      SEG_PRE: begin
        last_idx = IDX_W'(w_cmd_r.pre_cnt - 2'd1);
        cur_byte = TAG_OPEN[idx_r[1:0]];
      end
      SEG_POST: begin
        last_idx = IDX_W'(w_cmd_r.post_cnt - 2'd1);
        cur_byte = TAG_OPEN[idx_r[1:0]];
      end
      SEG_Q_MID, SEG_END_Q: begin
        cur_byte = CH_QMARK;
      end
      SEG_ESC: begin
        cur_byte = CH_BSL;
      end
      SEG_BYTE: begin
        cur_byte = w_cmd_r.byte_val;
      end
      default: begin
        cur_byte = w_cmd_r.byte_val;
      end
    endcase
  end

  assign seg_done = (idx_r == last_idx);
  assign rest     = mask_r & ~(NUM_SEG'(1) << seg);
  assign run_last = seg_done && (rest == '0);
  assign adv      = !out_valid_r || out_ready;
  assign emit     = w_valid_r && adv;
  assign load     = q_valid && (!w_valid_r || (emit && run_last));
  assign pop      = load;

  always_comb begin
    w_valid_nxt = w_valid_r;
    mask_nxt    = mask_r;
    idx_nxt     = idx_r;
    if (load) begin
      w_valid_nxt = 1'b1;
      mask_nxt    = cmd_mask(q_cmd);
      idx_nxt     = '0;
    end else if (emit) begin
      if (run_last) begin
        w_valid_nxt = 1'b0;
      end
      if (seg_done) begin
        mask_nxt = rest;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r   <= 1'b0;
      mask_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      w_valid_r <= w_valid_nxt;
      mask_r    <= mask_nxt;
      idx_r     <= idx_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w_cmd_r <= q_cmd;
    end
    if (emit) begin
      out_item_r.out_byte <= cur_byte;
      out_item_r.run_last <= run_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/template_tag_script_escaper.sv -----
// A byte's command passes the queue, the back end's working register and the output register.
// Throughput: one result byte per cycle while out_ready does not stall; an input byte is taken
// every cycle while the four-entry command queue has room, so the output port sets the sustained
// rate (most bytes give one or two results, a fixed string up to 20).
// Reset: synchronous, active low; clears the tag state, the queue and the output register.
`default_nettype none

module template_tag_script_escaper
  import tse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  tse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tse_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/tse_checker.sv -----
`default_nettype none

module tse_checker
  import tse_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  logic first_r;

  // set until the first result transaction after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= 1'b0;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input transaction dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result transaction dropped or changed while stalled");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_first_open: assert property (@(posedge clk) disable iff (!rst_n)
    first_r && out_valid |-> out_item.out_byte == OPEN_STR[0] && !out_item.run_last)
    else $error("document does not begin with the opening string");

endmodule

bind template_tag_script_escaper tse_checker u_chk (.*);

`default_nettype wire
